// ----- rtl/core/mid_pkg.sv -----
// ----------------------------------------------------------------------------
// mid_pkg
// Shared types, opcode patterns and decode helpers for the MOV stream decoder.
// ----------------------------------------------------------------------------
package mid_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int DATA_W      = 56;

  localparam logic [7:0] MASK_RM_REG    = 8'hFC;
  localparam logic [7:0] MASK_W_FORM    = 8'hFE;
  localparam logic [7:0] MASK_IMM_REG   = 8'hF0;
  localparam logic [7:0] OPC_RM_REG     = 8'h88;
  localparam logic [7:0] OPC_IMM_TO_RM  = 8'hC6;
  localparam logic [7:0] OPC_IMM_TO_REG = 8'hB0;
  localparam logic [7:0] OPC_MEM_TO_ACC = 8'hA0;
  localparam logic [7:0] OPC_ACC_TO_MEM = 8'hA2;

  localparam logic [1:0] MOD_NO_DISP = 2'b00;
  localparam logic [1:0] MOD_DISP8   = 2'b01;
  localparam logic [1:0] MOD_DISP16  = 2'b10;
  localparam logic [2:0] RM_DIRECT   = 3'b110;

  typedef enum logic [2:0] {
    FORM_RM_REG     = 3'd0,
    FORM_IMM_TO_RM  = 3'd1,
    FORM_IMM_TO_REG = 3'd2,
    FORM_MEM_TO_ACC = 3'd3,
    FORM_ACC_TO_MEM = 3'd4,
    FORM_INVALID    = 3'd7
  } form_t;

  // raw record as assembled by the front end
  typedef struct packed {
    logic        err;
    form_t       form;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [2:0]  length;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } rec_slot_t;

  // output tdata layout, form in the lowest bits
  typedef struct packed {
    logic [7:0]  opcode_byte;
    logic [2:0]  length;
    logic [15:0] immediate;
    logic [15:0] displacement;
    logic [2:0]  rm_code;
    logic [1:0]  mode_code;
    logic [2:0]  reg_code;
    logic        wide;
    logic        to_register;
    logic [2:0]  form;
  } out_t;

  function automatic form_t classify(input logic [7:0] b);
    form_t f;
    if ((b & MASK_RM_REG) == OPC_RM_REG) f = FORM_RM_REG;
    else if ((b & MASK_W_FORM) == OPC_IMM_TO_RM) f = FORM_IMM_TO_RM;
    else if ((b & MASK_IMM_REG) == OPC_IMM_TO_REG) f = FORM_IMM_TO_REG;
    else if ((b & MASK_W_FORM) == OPC_MEM_TO_ACC) f = FORM_MEM_TO_ACC;
    else if ((b & MASK_W_FORM) == OPC_ACC_TO_MEM) f = FORM_ACC_TO_MEM;
    else f = FORM_INVALID;
    return f;
  endfunction

  function automatic logic wide_bit(input form_t f, input logic [7:0] op);
    return (f == FORM_IMM_TO_REG) ? op[3] : op[0];
  endfunction

  function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
    logic [1:0] n;
    case (modrm[7:6])
      MOD_DISP8:   n = 2'd1;
      MOD_DISP16:  n = 2'd2;
      MOD_NO_DISP: n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
      default:     n = 2'd0;
    endcase
    return n;
  endfunction

  // low byte goes in sign-extended, high byte replaces the upper half
  function automatic logic [15:0] place_byte(input logic [15:0] acc, input logic hi,
                                             input logic [7:0] b);
    return hi ? {b, acc[7:0]} : {{8{b[7]}}, b};
  endfunction

endpackage

// ----- rtl/core/mid_front.sv -----
// ----------------------------------------------------------------------------
// mid_front
// Byte intake: classifies opcodes, tracks position and assembles records.
// ----------------------------------------------------------------------------
module mid_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // code_byte
  input  logic               q_ready,
  output mid_pkg::rec_slot_t push
);
  import mid_pkg::*;

  logic [2:0]  pos, pos_next, pos_inc, off;
  logic [2:0]  exp_len, len_next;
  form_t       form_q, form_next, byte_form;
  logic [7:0]  opcode, opcode_next;
  logic [7:0]  modrm, modrm_next;
  logic [15:0] disp, disp_next;
  logic [15:0] imm, imm_next;
  logic        w, bw, done, accept;
  logic [1:0]  db;
  rec_t        rec;

  assign s_tready = q_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    byte_form   = classify(s_tdata);
    bw          = wide_bit(byte_form, s_tdata);
    w           = wide_bit(form_q, opcode);
    db          = disp_bytes(modrm);
    off         = pos - 3'd2;
    pos_inc     = pos + 3'd1;
    pos_next    = pos;
    len_next    = exp_len;
    form_next   = form_q;
    opcode_next = opcode;
    modrm_next  = modrm;
    disp_next   = disp;
    imm_next    = imm;
    done        = 1'b0;
    rec         = '0;
    if (pos == 3'd0) begin
      if (byte_form == FORM_INVALID) begin
        done       = 1'b1;
        rec.err    = 1'b1;
        rec.form   = FORM_INVALID;
        rec.opcode = s_tdata;
        rec.length = 3'd1;
      end else begin
        form_next   = byte_form;
        opcode_next = s_tdata;
        modrm_next  = '0;
        disp_next   = '0;
        imm_next    = '0;
        pos_next    = 3'd1;
        case (byte_form)
          FORM_IMM_TO_REG: len_next = 3'd2 + {2'b00, bw};
          FORM_MEM_TO_ACC,
          FORM_ACC_TO_MEM: len_next = 3'd3;
          default:         len_next = 3'd0;
        endcase
      end
    end else begin
      case (form_q)
        FORM_RM_REG, FORM_IMM_TO_RM: begin
          if (pos == 3'd1) begin
            modrm_next = s_tdata;
            len_next   = 3'd2 + {1'b0, disp_bytes(s_tdata)}
                       + ((form_q == FORM_IMM_TO_RM) ? (3'd1 + {2'b00, w}) : 3'd0);
          end else if (off < {1'b0, db}) begin
            disp_next = place_byte(disp, off[0], s_tdata);
          end else begin
            imm_next = place_byte(imm, off[0] ^ db[0], s_tdata);
          end
        end
        FORM_IMM_TO_REG: imm_next = place_byte(imm, ~pos[0], s_tdata);
        default:         disp_next = place_byte(disp, ~pos[0], s_tdata);
      endcase
      if (pos_inc >= len_next) begin
        done       = 1'b1;
        pos_next   = 3'd0;
        rec.form   = form_q;
        rec.opcode = opcode;
        rec.modrm  = modrm_next;
        rec.disp   = disp_next;
        rec.imm    = imm_next;
        rec.length = len_next;
      end else begin
        pos_next = pos_inc;
      end
    end
  end

  assign push.valid = accept && done;
  assign push.rec   = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= 3'd0;
      exp_len <= 3'd0;
    end else if (accept) begin
      pos     <= pos_next;
      exp_len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      form_q <= form_next;
      opcode <= opcode_next;
      modrm  <= modrm_next;
      disp   <= disp_next;
      imm    <= imm_next;
    end
  end

endmodule

// ----- rtl/core/mid_queue.sv -----
// ----------------------------------------------------------------------------
// mid_queue
// Small record FIFO between the front end and the output stage.
// ----------------------------------------------------------------------------
module mid_queue #(
  parameter int Depth = mid_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  mid_pkg::rec_slot_t push,
  output logic               ready,
  output mid_pkg::rec_slot_t head,
  input  logic               pop
);
  import mid_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rec_t            mem [Depth];
  logic [PtrW-1:0] wr, rd;
  logic [CntW-1:0] count, count_next;
  logic            do_push, do_pop;

  assign do_push = push.valid;
  assign do_pop  = pop && (count != '0);
  assign ready   = count != CntW'(Depth);

  assign head.valid = count != '0;
  assign head.rec   = mem[rd];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (do_push) wr <= (wr == PtrW'(Depth - 1)) ? '0 : wr + 1'b1;
      if (do_pop)  rd <= (rd == PtrW'(Depth - 1)) ? '0 : rd + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr] <= push.rec;
  end

endmodule

// ----- rtl/core/mid_back.sv -----
// ----------------------------------------------------------------------------
// mid_back
// Output stage: formats queued records into the result fields and registers
// them toward the master side.
// ----------------------------------------------------------------------------
module mid_back (
  input  logic                       clk,
  input  logic                       rst,
  input  mid_pkg::rec_slot_t         head,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // form, to_register, wide, reg_code, mode_code, rm_code, displacement,
  // immediate, length, opcode_byte
  output logic [mid_pkg::DATA_W-1:0] m_tdata,
  output logic                       m_tuser    // status
);
  import mid_pkg::*;

  rec_t r;
  out_t o;
  logic has_modrm;

  assign r         = head.rec;
  assign pop       = head.valid && (!m_tvalid || m_tready);
  assign has_modrm = (r.form == FORM_RM_REG) || (r.form == FORM_IMM_TO_RM);

  always_comb begin
    o             = '0;
    o.opcode_byte = r.opcode;
    o.length      = r.length;
    if (!r.err) begin
      o.form         = r.form;
      o.wide         = wide_bit(r.form, r.opcode);
      o.to_register  = (r.form == FORM_RM_REG) ? r.opcode[1]
                     : ((r.form == FORM_IMM_TO_REG) || (r.form == FORM_MEM_TO_ACC));
      o.reg_code     = (r.form == FORM_RM_REG) ? r.modrm[5:3]
                     : (r.form == FORM_IMM_TO_REG) ? r.opcode[2:0] : 3'd0;
      o.mode_code    = has_modrm ? r.modrm[7:6] : 2'd0;
      o.rm_code      = has_modrm ? r.modrm[2:0] : 3'd0;
      o.displacement = r.disp;
      o.immediate    = r.imm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= o;
      m_tuser <= r.err;
    end
  end

endmodule

// ----- rtl/core/mov_instruction_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// mov_instruction_stream_decoder
// Byte-serial decoder for the five 8086 MOV forms.
//
// The slave side takes one code byte per item (s_tdata). The master side
// gives one record per instruction after its last byte: m_tuser is the
// status (1 for an unrecognized opcode byte, reported as a one-byte record),
// m_tdata carries the decoded fields and the instruction length.
// Throughput is one byte per clock, sustained while s_tready is high. A
// record is written into the record queue when its last byte is taken, then
// moves into the output register that drives m_tvalid and m_tdata; it is
// taken while m_tready is high.
// Reset clears the byte position (next byte is an opcode), empties the
// queue and drops m_tvalid.
// When the receiver stalls, finished records collect in the queue and the
// output register; s_tready falls only once the queue is full, and bytes
// that finish no instruction are still only taken while the queue has room.
// ----------------------------------------------------------------------------
module mov_instruction_stream_decoder #(
  parameter int QueueDepth = mid_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // code_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // form, to_register, wide, reg_code, mode_code, rm_code, displacement,
  // immediate, length, opcode_byte
  output logic [mid_pkg::DATA_W-1:0] m_tdata,
  output logic                       m_tuser    // status
);
  import mid_pkg::*;

  rec_slot_t push, head;
  logic      q_ready, pop;
  out_t      mo;

  mid_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_ready  (q_ready),
    .push     (push)
  );

  mid_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .ready (q_ready),
    .head  (head),
    .pop   (pop)
  );

  mid_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  assign mo = out_t'(m_tdata);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> q_ready)
    else $error("record pushed into full queue");

  a_err_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (mo.length == 3'd1 && mo.form == FORM_RM_REG))
    else $error("error record malformed");

  a_dec_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      (mo.length >= 3'd2 && mo.length <= 3'd6 && mo.form <= FORM_ACC_TO_MEM))
    else $error("decoded record length or form out of range");

endmodule
